>>> rtl/ult_pkg.sv
// shared types and constants for the unsorted list table
package ult_pkg;

   localparam int DEPTH_DEF = 64;
   localparam int DATA_W    = 32;
   localparam int FUNC_W    = 2;
   localparam int STAT_W    = 2;
   localparam int POS_W     = 6;
   localparam int CNT_W     = 7;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT   = 2'd0,
      FUNC_DELETE   = 2'd1,
      FUNC_RETRIEVE = 2'd2,
      FUNC_CLEAR    = 2'd3
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_EMPTY     = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESULT
   } state_type;

endpackage

>>> rtl/unsorted_list_table.sv
// unsorted list table: insertion-ordered list of signed 32-bit entries in one ram
// one request at a time; insert, clear and delete or retrieve on an empty list go straight
//   to the result state, load the result once the output register is free, then take the next request in idle
// delete and retrieve scan one entry per cycle unless a rsp stall holds back a retrieve hit;
//   the final result is loaded from the result state after every entry is read and checked
// synchronous reset clears count and control state; the ram is not swept, only read below count

module unsorted_list_table import ult_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [FUNC_W-1:0]        req_func,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [STAT_W-1:0]        rsp_status,
   output logic                     rsp_found,
   output logic [POS_W-1:0]         rsp_position,
   output logic [CNT_W-1:0]         rsp_count,
   output logic                     rsp_is_empty,
   output logic                     rsp_is_full,
   output logic                     rsp_last
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   // control state
   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic        dv_ff, dv_in;          // read data from the ram is valid this cycle
   logic        hit_ff, hit_in;        // delete has found its entry, now shifting down
   logic        pend_ff, pend_in;      // a retrieve hit is held until the next one shows up or the scan ends
   logic        rsp_valid_ff, rsp_valid_in;

   // working payload
   func_type             func_ff, func_in;
   logic [DATA_W-1:0]    value_ff, value_in;
   logic [CW-1:0]        rd_addr_ff, rd_addr_in;
   logic [AW-1:0]        da_ff, da_in;             // address of the data now on rd_data
   logic [AW-1:0]        pend_pos_ff, pend_pos_in;
   status_type           res_status_ff, res_status_in;
   logic                 res_found_ff, res_found_in;
   logic [AW-1:0]        res_pos_ff, res_pos_in;

   // output register payload
   logic [STAT_W-1:0]    rsp_status_ff, rsp_status_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]     rsp_position_ff, rsp_position_in;
   logic [CNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic                 rsp_is_empty_ff, rsp_is_empty_in;
   logic                 rsp_is_full_ff, rsp_is_full_in;
   logic                 rsp_last_ff, rsp_last_in;

   // ram port
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [DATA_W-1:0] rd_data;

   // result push into the output register
   logic       push;
   status_type push_status;
   logic       push_found;
   logic [AW-1:0] push_pos;
   logic       push_last;

   logic out_free;
   logic eq;
   logic stall;

   // the delete shift writes one place below an address already read, and insert writes
   // only while no read is in flight, so a read and a write never meet on one entry
   ult_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign eq       = (rd_data == value_ff);
   assign rd_addr  = rd_addr_ff[AW-1:0];

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      dv_in         = dv_ff;
      hit_in        = hit_ff;
      pend_in       = pend_ff;
      func_in       = func_ff;
      value_in      = value_ff;
      rd_addr_in    = rd_addr_ff;
      da_in         = da_ff;
      pend_pos_in   = pend_pos_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_pos_in    = res_pos_ff;

      req_ready   = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = '0;
      rd_en       = 1'b0;
      stall       = 1'b0;
      push        = 1'b0;
      push_status = STAT_OK;
      push_found  = 1'b0;
      push_pos    = '0;
      push_last   = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in       = func_type'(req_func);
               value_in      = req_value;
               hit_in        = 1'b0;
               pend_in       = 1'b0;
               dv_in         = 1'b0;
               rd_addr_in    = '0;
               res_status_in = STAT_OK;
               res_found_in  = 1'b0;
               res_pos_in    = '0;
               state_in      = ST_RESULT;
               case (func_type'(req_func))
                  FUNC_INSERT: begin
                     if (count_ff == FULL_COUNT) begin
                        res_status_in = STAT_FULL;
                     end else begin
                        // append at the tail
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_data  = req_value;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  FUNC_DELETE: begin
                     if (count_ff == '0) begin
                        res_status_in = STAT_EMPTY;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  FUNC_RETRIEVE: begin
                     if (count_ff == '0) begin
                        res_status_in = STAT_NOT_FOUND;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  FUNC_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // compare stage: look at the entry now on rd_data
            if (dv_ff) begin
               if (func_ff == FUNC_DELETE) begin
                  if (hit_ff) begin
                     // move this entry down one place over the removed one
                     wr_en   = 1'b1;
                     wr_addr = da_ff - AW'(1);
                     wr_data = rd_data;
                  end else if (eq) begin
                     hit_in = 1'b1;
                  end
               end else if (eq) begin
                  // retrieve: a new hit means the held one is not the final result
                  if (pend_ff) begin
                     if (out_free) begin
                        push        = 1'b1;
                        push_status = STAT_OK;
                        push_found  = 1'b1;
                        push_pos    = pend_pos_ff;
                        push_last   = 1'b0;
                        pend_pos_in = da_ff;
                     end else begin
                        stall = 1'b1;
                     end
                  end else begin
                     pend_in     = 1'b1;
                     pend_pos_in = da_ff;
                  end
               end
            end

            // read stage: issue the next address unless the compare stage holds
            if (!stall) begin
               if (rd_addr_ff != count_ff) begin
                  rd_en      = 1'b1;
                  rd_addr_in = rd_addr_ff + CW'(1);
                  da_in      = rd_addr_ff[AW-1:0];
                  dv_in      = 1'b1;
               end else begin
                  dv_in = 1'b0;
                  if (!dv_ff) begin
                     // every entry read and checked
                     state_in = ST_RESULT;
                     if (func_ff == FUNC_DELETE) begin
                        if (hit_ff) begin
                           count_in      = count_ff - CW'(1);
                           res_status_in = STAT_OK;
                        end else begin
                           res_status_in = STAT_NOT_FOUND;
                        end
                     end else if (pend_ff) begin
                        res_status_in = STAT_OK;
                        res_found_in  = 1'b1;
                        res_pos_in    = pend_pos_ff;
                     end else begin
                        res_status_in = STAT_NOT_FOUND;
                     end
                  end
               end
            end
         end

         ST_RESULT: begin
            if (out_free) begin
               push        = 1'b1;
               push_status = res_status_ff;
               push_found  = res_found_ff;
               push_pos    = res_pos_ff;
               push_last   = 1'b1;
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register: loaded on push, emptied on a rsp transfer
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_is_empty_in = rsp_is_empty_ff;
      rsp_is_full_in  = rsp_is_full_ff;
      rsp_last_in     = rsp_last_ff;
      if (push) begin
         rsp_valid_in    = 1'b1;
         rsp_status_in   = push_status;
         rsp_found_in    = push_found;
         rsp_position_in = POS_W'(push_pos);
         rsp_count_in    = CNT_W'(count_ff);
         rsp_is_empty_in = (count_ff == '0);
         rsp_is_full_in  = (count_ff == FULL_COUNT);
         rsp_last_in     = push_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dv_ff        <= 1'b0;
         hit_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dv_ff        <= dv_in;
         hit_ff       <= hit_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff         <= func_in;
      value_ff        <= value_in;
      rd_addr_ff      <= rd_addr_in;
      da_ff           <= da_in;
      pend_pos_ff     <= pend_pos_in;
      res_status_ff   <= res_status_in;
      res_found_ff    <= res_found_in;
      res_pos_ff      <= res_pos_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_is_empty_ff <= rsp_is_empty_in;
      rsp_is_full_ff  <= rsp_is_full_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_is_empty = rsp_is_empty_ff;
   assign rsp_is_full  = rsp_is_full_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

>>> rtl/ult_ram.sv
// entry store: one write port, one read port with registered read data
module ult_ram import ult_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF,
   parameter int AW    = POS_W
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ult_checker.sv
// port-level checks for the unsorted list table, bound to the top level
module ult_checker import ult_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [STAT_W-1:0] rsp_status,
   input logic              rsp_found,
   input logic [POS_W-1:0]  rsp_position,
   input logic [CNT_W-1:0]  rsp_count,
   input logic              rsp_is_empty,
   input logic              rsp_last
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_found)
         && $stable(rsp_position) && $stable(rsp_count) && $stable(rsp_last))
      else $error("stalled result changed");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_is_empty == (rsp_count == '0))
      else $error("empty flag disagrees with count");

   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == STAT_OK && CNT_W'(rsp_position) < rsp_count)
      else $error("hit position outside the list");

   a_only_hits_continue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_found)
      else $error("non-final result that is not a hit");

endmodule

bind unsorted_list_table ult_checker u_ult_checker (.*);

>>> sim/unsorted_list_table_tb.sv
// self-checking testbench for the unsorted list table: directed table, then random traffic
module unsorted_list_table_tb;
   import ult_pkg::*;

   localparam int LIST_DEPTH       = DEPTH_DEF;
   localparam int HOLD_CYCLES      = 400;  // long rsp back-pressure stretch
   localparam int DRAIN_CYCLES     = 200;  // settle time after the last drain
   localparam int RANDOM_PER_PHASE = 50;
   localparam int MAX_PRINTED      = 40;

   // one result transfer as the list should report it
   typedef struct {
      status_type         status;
      logic               found;
      logic [POS_W-1:0]   position;
      logic [CNT_W-1:0]   count;
      logic               is_empty;
      logic               is_full;
      logic               last;
   } list_result_type;

   // directed stimulus row; typed rows carry a single expected result given in the row
   typedef struct {
      func_type           func;
      logic [DATA_W-1:0]  value;
      bit                 typed;
      status_type         status;
      logic [CNT_W-1:0]   count;
   } dir_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [FUNC_W-1:0]        req_func = FUNC_INSERT;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [STAT_W-1:0]        rsp_status;
   logic                     rsp_found;
   logic [POS_W-1:0]         rsp_position;
   logic [CNT_W-1:0]         rsp_count;
   logic                     rsp_is_empty;
   logic                     rsp_is_full;
   logic                     rsp_last;

   // shadow copy of the list, advanced on every request transfer
   logic [DATA_W-1:0] list_entries [LIST_DEPTH];
   int                list_count = 0;
   list_result_type   op_results[$];        // results of the request just predicted
   list_result_type   pending_results[$];   // results still owed by the block
   int                error_count = 0;

   // idling knobs
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_req      = 0;
   int hold_seen     = 0;
   int hold_left     = 0;

   // values that recur, so inserts, deletes and lookups hit each other
   logic [DATA_W-1:0] value_pool [8] = '{
      32'h0000_0000, 32'h0000_0001, 32'hffff_ffff, 32'h8000_0000,
      32'h7fff_ffff, 32'h5a5a_5a5a, 32'ha5a5_a5a5, 32'h1234_5678
   };

   // extremes, every operation and the empty and not-found statuses
   dir_row_type directed_rows [24] = '{
      '{FUNC_DELETE,   32'h0000_0000, 1'b1, STAT_EMPTY,     7'd0},  // delete on empty list
      '{FUNC_RETRIEVE, 32'h0000_0000, 1'b1, STAT_NOT_FOUND, 7'd0},  // lookup on empty list
      '{FUNC_CLEAR,    32'h0000_0000, 1'b1, STAT_OK,        7'd0},
      '{FUNC_INSERT,   32'h8000_0000, 1'b1, STAT_OK,        7'd1},  // most negative
      '{FUNC_INSERT,   32'h7fff_ffff, 1'b1, STAT_OK,        7'd2},  // most positive
      '{FUNC_INSERT,   32'h0000_0000, 1'b1, STAT_OK,        7'd3},
      '{FUNC_INSERT,   32'hffff_ffff, 1'b1, STAT_OK,        7'd4},
      '{FUNC_INSERT,   32'h8000_0000, 1'b1, STAT_OK,        7'd5},  // duplicate
      '{FUNC_RETRIEVE, 32'h8000_0000, 1'b0, STAT_OK,        7'd0},  // two hits
      '{FUNC_RETRIEVE, 32'h7fff_ffff, 1'b0, STAT_OK,        7'd0},  // single hit
      '{FUNC_RETRIEVE, 32'h0000_0001, 1'b1, STAT_NOT_FOUND, 7'd5},  // near miss
      '{FUNC_DELETE,   32'h7fff_fffe, 1'b1, STAT_NOT_FOUND, 7'd5},
      '{FUNC_DELETE,   32'h8000_0000, 1'b0, STAT_OK,        7'd0},  // first of two, shifts
      '{FUNC_RETRIEVE, 32'h8000_0000, 1'b0, STAT_OK,        7'd0},
      '{FUNC_DELETE,   32'hffff_ffff, 1'b0, STAT_OK,        7'd0},
      '{FUNC_DELETE,   32'h7fff_ffff, 1'b0, STAT_OK,        7'd0},  // head entry
      '{FUNC_CLEAR,    32'hffff_ffff, 1'b1, STAT_OK,        7'd0},
      '{FUNC_RETRIEVE, 32'h0000_0000, 1'b1, STAT_NOT_FOUND, 7'd0},  // stale entries hidden
      '{FUNC_INSERT,   32'h5555_5555, 1'b1, STAT_OK,        7'd1},
      '{FUNC_INSERT,   32'haaaa_aaaa, 1'b1, STAT_OK,        7'd2},
      '{FUNC_RETRIEVE, 32'haaaa_aaaa, 1'b0, STAT_OK,        7'd0},
      '{FUNC_DELETE,   32'h5555_5555, 1'b0, STAT_OK,        7'd0},
      '{FUNC_DELETE,   32'haaaa_aaaa, 1'b1, STAT_OK,        7'd0},  // back to empty
      '{FUNC_DELETE,   32'haaaa_aaaa, 1'b1, STAT_EMPTY,     7'd0}
   };

   unsorted_list_table u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_found    (rsp_found),
      .rsp_position (rsp_position),
      .rsp_count    (rsp_count),
      .rsp_is_empty (rsp_is_empty),
      .rsp_is_full  (rsp_is_full),
      .rsp_last     (rsp_last)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- list predictor

   // flags and count always reflect the list after the operation
   function automatic void add_op_result(status_type st, logic hit, int pos, logic is_last);
      list_result_type r;
      r.status   = st;
      r.found    = hit;
      r.position = POS_W'(pos);
      r.count    = CNT_W'(list_count);
      r.is_empty = (list_count == 0);
      r.is_full  = (list_count == LIST_DEPTH);
      r.last     = is_last;
      op_results.push_back(r);
   endfunction

   function automatic void predict_list_op(func_type f, logic [DATA_W-1:0] v);
      int match_at;
      int hits;
      int k;
      op_results.delete();
      match_at = -1;
      hits     = 0;
      k        = 0;
      // equality is on the raw 32-bit pattern
      for (int i = 0; i < list_count; i++) begin
         if (list_entries[i] == v) begin
            hits++;
            if (match_at < 0) match_at = i;
         end
      end
      case (f)
         FUNC_INSERT: begin
            if (list_count >= LIST_DEPTH) begin
               add_op_result(STAT_FULL, 1'b0, 0, 1'b1);
            end else begin
               list_entries[list_count] = v;
               list_count++;
               add_op_result(STAT_OK, 1'b0, 0, 1'b1);
            end
         end
         FUNC_DELETE: begin
            if (list_count == 0) begin
               add_op_result(STAT_EMPTY, 1'b0, 0, 1'b1);
            end else if (match_at < 0) begin
               add_op_result(STAT_NOT_FOUND, 1'b0, 0, 1'b1);
            end else begin
               // close the gap: later entries move down one place
               for (int j = match_at; j + 1 < list_count; j++)
                  list_entries[j] = list_entries[j + 1];
               list_count--;
               add_op_result(STAT_OK, 1'b0, 0, 1'b1);
            end
         end
         FUNC_RETRIEVE: begin
            // one result per hit in ascending position, last flag on the final one
            for (int i = 0; i < list_count; i++) begin
               if (list_entries[i] == v) begin
                  k++;
                  add_op_result(STAT_OK, 1'b1, i, k == hits);
               end
            end
            if (hits == 0) add_op_result(STAT_NOT_FOUND, 1'b0, 0, 1'b1);
         end
         default: begin
            list_count = 0;
            add_op_result(STAT_OK, 1'b0, 0, 1'b1);
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- request side

   // offer one request, hold it until the transfer, then book its results
   task automatic send_op(func_type f, logic [DATA_W-1:0] v, bit typed = 1'b0,
                          status_type st = STAT_OK, logic [CNT_W-1:0] cnt = '0);
      list_result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= f;
      req_value <= v;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_list_op(f, v);
      if (typed) begin
         r.status   = st;
         r.found    = 1'b0;
         r.position = '0;
         r.count    = cnt;
         r.is_empty = (cnt == 0);
         r.is_full  = (cnt == LIST_DEPTH);
         r.last     = 1'b1;
         pending_results.push_back(r);
      end else begin
         foreach (op_results[i]) pending_results.push_back(op_results[i]);
      end
   endtask

   // mostly lookups and deletes of values that are stored, so scans find something
   task automatic send_random_op();
      int               pick;
      func_type         f;
      logic [DATA_W-1:0] v;
      pick = $urandom_range(99);
      if (pick < 45) begin
         f = FUNC_INSERT;
         v = ($urandom_range(99) < 60) ? value_pool[$urandom_range(7)] : $urandom;
      end else if (pick < 97) begin
         f = (pick < 68) ? FUNC_DELETE : FUNC_RETRIEVE;
         if (list_count > 0 && $urandom_range(99) < 78)
            v = list_entries[$urandom_range(list_count - 1)];
         else
            v = $urandom_range(1) ? value_pool[$urandom_range(7)] : $urandom;
      end else begin
         f = FUNC_CLEAR;
         v = $urandom;
      end
      send_op(f, v);
   endtask

   // run the list up to full, push past it, then scan and delete at full length
   task automatic fill_list(bit same_value);
      logic [DATA_W-1:0] v;
      v = value_pool[$urandom_range(7)];
      // starting from empty with one value gives a hit on every position
      if (same_value) send_op(FUNC_CLEAR, $urandom);
      while (list_count < LIST_DEPTH)
         send_op(FUNC_INSERT, same_value ? v : value_pool[$urandom_range(7)]);
      send_op(FUNC_INSERT, $urandom);   // refused, list full
      send_op(FUNC_RETRIEVE, v);
      send_op(FUNC_DELETE, v);
      send_op(FUNC_RETRIEVE, v);
      send_op(FUNC_INSERT, $urandom);   // refills the last slot
      send_op(FUNC_INSERT, $urandom);   // refused again
   endtask

   // sender steps back until every booked result has come out
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- result side

   task automatic report_mismatch(string msg);
      error_count++;
      if (error_count <= MAX_PRINTED) $display("%0t: mismatch: %s", $time, msg);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // receiver: random stalls, plus a long hold whenever the sender asks for one
   always @(posedge clock) begin
      if (hold_seen != hold_req) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // every result transfer is matched against the oldest booked result
   always @(posedge clock) begin : check_rsp
      list_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending, status %0h count %0d",
                                      rsp_status, rsp_count));
         end else begin
            want = pending_results.pop_front();
            check_field("status",   32'(rsp_status),   32'(want.status));
            check_field("found",    32'(rsp_found),    32'(want.found));
            check_field("position", 32'(rsp_position), 32'(want.position));
            check_field("count",    32'(rsp_count),    32'(want.count));
            check_field("is_empty", 32'(rsp_is_empty), 32'(want.is_empty));
            check_field("is_full",  32'(rsp_is_full),  32'(want.is_full));
            check_field("last",     32'(rsp_last),     32'(want.last));
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_op(directed_rows[i].func, directed_rows[i].value, directed_rows[i].typed,
                 directed_rows[i].status, directed_rows[i].count);
      drain_results();

      // phases: no idling, sender idle, receiver stalls, both a little
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct     <= 0;
            end
            1: begin
               send_idle_pct = 63;
               stall_pct     <= 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     <= 63;
            end
            default: begin
               send_idle_pct = 12;
               stall_pct     <= 12;
            end
         endcase
         // receiver holds off while requests keep coming, so the input backs up
         if (phase == 0) begin
            hold_req <= hold_req + 1;
            repeat (12) send_random_op();
         end
         repeat (RANDOM_PER_PHASE) send_random_op();
         if (phase == 0)
            fill_list(1'b1);
         else if (phase == 3)
            fill_list(1'b0);
         drain_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // hard stop, far beyond the slowest correct run
   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

>>> filelist.f
rtl/ult_pkg.sv
rtl/ult_ram.sv
rtl/unsorted_list_table.sv
rtl/ult_checker.sv
sim/unsorted_list_table_tb.sv
